// ===== hdl/vpts_pkg.sv =====
// ----------------------------------------------------------------------------
// Video playout time scheduler package
// Shared widths, constants, register codes and payload types.
// ----------------------------------------------------------------------------
package vpts_pkg;

  localparam int COUNT_BITS = 16;

  localparam int STAMP_W    = 32;
  localparam int RATE_W     = 6;
  localparam int SEQ_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int MS_PER_SEC    = 1000;
  localparam int GAP_MIN       = 16;
  localparam int GAP_MAX       = 1000;
  localparam int GAP_FALLBACK  = 80;
  localparam int FALLBACK_NEXT = MS_PER_SEC / GAP_FALLBACK;

  localparam int MS_W   = 10;
  localparam int PROD_W = COUNT_BITS + MS_W;
  localparam int DIV_W  = (PROD_W > STAMP_W) ? PROD_W : STAMP_W;
  localparam int DVSR_W = 10;
  localparam int LEN_W  = $clog2(DIV_W + 1);

  localparam logic [CFG_DATA_W-1:0] RESET_TICKS = CFG_DATA_W'(16);
  localparam logic [CFG_DATA_W-1:0] RESET_DELAY = CFG_DATA_W'(30);
  localparam logic [RATE_W-1:0]     RESET_RATE  = RATE_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_TICKS  = 2'd1,
    CFG_DELAY  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_AUDIO = 1'b0,
    MODE_VIDEO = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] codec_lead;
    logic [SEQ_W-1:0]   packet_seq;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [STAMP_W-1:0] play_time;
    logic [RATE_W-1:0]  frame_rate;
    logic [SEQ_W-1:0]   out_seq;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
    logic [LEN_W-1:0]  len;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/vpts_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; the dividend arrives
// left-aligned and len gives the number of quotient bits to develop.
// ----------------------------------------------------------------------------
module vpts_div
  import vpts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DVSR_W-1:0] rem_q, rem_d;
  logic [DVSR_W-1:0] dvsr_q, dvsr_d;
  logic [DIV_W-1:0]  quo_q, quo_d;

  logic [DVSR_W:0]   shifted;
  logic [DVSR_W+1:0] diff;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.len;
      rem_d  = '0;
      dvsr_d = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - LEN_W'(1);
        if (diff[DVSR_W+1]) begin
          rem_d = shifted[DVSR_W-1:0];
          quo_d = {quo_q[DIV_W-2:0], 1'b0};
        end else begin
          rem_d = diff[DVSR_W-1:0];
          quo_d = {quo_q[DIV_W-2:0], 1'b1};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/video_playout_time_scheduler.sv =====
// Audio event: busy through load, 32 serial divide steps and write-back.
// Video packet, new stamp, gap in range: a step divide, then a rate divide, then the result.
// Video packet, new stamp, gap out of range: a step divide only, then the result.
// Repeated stamp or rejected packet: no divide; the result goes out through ST_DONE.
// One request at a time; every divide above uses the shared bit-serial divider.
// Reset (async, active low) restores registers and estimator state to defaults.
// ----------------------------------------------------------------------------
// Video playout time scheduler
// Tracks the audio reference and frame count, predicts frame times, smooths
// the frame rate and assigns a play time to each accepted video packet.
// ----------------------------------------------------------------------------
module video_playout_time_scheduler
  import vpts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AUDIO,
    ST_STEP,
    ST_RATE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic                  en_q, en_d;
  logic [CFG_DATA_W-1:0] ticks_q, ticks_d;
  logic [CFG_DATA_W-1:0] delay_q, delay_d;

  logic [STAMP_W-1:0]    ref_q, ref_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [STAMP_W-1:0]    pred_q, pred_d;
  logic [STAMP_W-1:0]    last_q, last_d;
  logic [RATE_W-1:0]     rate_q, rate_d;

  logic [STAMP_W-1:0]    lead_adj_q, lead_adj_d;
  logic [SEQ_W-1:0]      seq_q, seq_d;
  logic [DVSR_W-1:0]     gap_q, gap_d;
  logic                  gap_ok_q, gap_ok_d;
  logic                  acc_q, acc_d;

  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [STAMP_W-1:0]    gap;
  logic [PROD_W-1:0]     prod;
  logic [7:0]            rate_sum3;
  logic [RATE_W:0]       rate_sum2;
  logic [RATE_W-1:0]     rate_dvsr;
  logic [CFG_DATA_W-1:0] ticks_dvsr;

  vpts_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign gap        = in_data_i.stamp - last_q;
  assign prod       = PROD_W'(count_q) * PROD_W'(MS_PER_SEC);
  assign rate_sum3  = {2'b00, rate_q} + {1'b0, rate_q, 1'b0} + 8'(FALLBACK_NEXT + 2);
  assign rate_sum2  = {1'b0, rate_q} + {1'b0, div_rsp.quotient[RATE_W-1:0]} + (RATE_W+1)'(1);
  assign rate_dvsr  = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign ticks_dvsr = (ticks_q == '0) ? CFG_DATA_W'(1) : ticks_q;

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    ticks_d     = ticks_q;
    delay_d     = delay_q;
    ref_d       = ref_q;
    count_d     = count_q;
    pred_d      = pred_q;
    last_d      = last_q;
    rate_d      = rate_q;
    lead_adj_d  = lead_adj_q;
    seq_d       = seq_q;
    gap_d       = gap_q;
    gap_ok_d    = gap_ok_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: en_d    = cfg_data_i[0];
        CFG_TICKS:  ticks_d = cfg_data_i;
        CFG_DELAY:  delay_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          seq_d      = in_data_i.packet_seq;
          lead_adj_d = in_data_i.codec_lead - STAMP_W'(delay_q);
          if (in_data_i.mode == MODE_AUDIO) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(in_data_i.stamp) << (DIV_W - STAMP_W);
            div_req.divisor  = DVSR_W'(ticks_dvsr);
            div_req.len      = LEN_W'(STAMP_W);
            state_d          = ST_AUDIO;
          end else if (!en_q) begin
            acc_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            acc_d    = 1'b1;
            last_d   = in_data_i.stamp;
            gap_d    = gap[DVSR_W-1:0];
            gap_ok_d = (gap >= STAMP_W'(GAP_MIN)) && (gap <= STAMP_W'(GAP_MAX));
            if (in_data_i.stamp != last_q) begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(prod) << (DIV_W - PROD_W);
              div_req.divisor  = DVSR_W'(rate_dvsr);
              div_req.len      = LEN_W'(PROD_W);
              state_d          = ST_STEP;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_AUDIO: begin
        if (div_rsp.done) begin
          ref_d   = div_rsp.quotient[STAMP_W-1:0];
          count_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (div_rsp.done) begin
          pred_d = ref_q + div_rsp.quotient[STAMP_W-1:0];
          if (count_q != '1) begin
            count_d = count_q + COUNT_BITS'(1);
          end
          if (gap_ok_q) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(MS_PER_SEC) << (DIV_W - MS_W);
            div_req.divisor  = gap_q;
            div_req.len      = LEN_W'(MS_W);
            state_d          = ST_RATE;
          end else begin
            rate_d  = rate_sum3[7:2];
            state_d = ST_DONE;
          end
        end
      end
      ST_RATE: begin
        if (div_rsp.done) begin
          rate_d  = rate_sum2[RATE_W:1];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.accepted   = acc_q;
          out_d.play_time  = acc_q ? (pred_q + lead_adj_q) : '0;
          out_d.frame_rate = rate_q;
          out_d.out_seq    = seq_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      en_q        <= 1'b0;
      ticks_q     <= RESET_TICKS;
      delay_q     <= RESET_DELAY;
      ref_q       <= '0;
      count_q     <= '0;
      pred_q      <= '0;
      last_q      <= '0;
      rate_q      <= RESET_RATE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      en_q        <= en_d;
      ticks_q     <= ticks_d;
      delay_q     <= delay_d;
      ref_q       <= ref_d;
      count_q     <= count_d;
      pred_q      <= pred_d;
      last_q      <= last_d;
      rate_q      <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_adj_q <= lead_adj_d;
    seq_q      <= seq_d;
    gap_q      <= gap_d;
    gap_ok_q   <= gap_ok_d;
    acc_q      <= acc_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef NO_ASSERTIONS
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_AUDIO || state_q == ST_STEP || state_q == ST_RATE))
    else $error("divider busy outside a divide state");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken without leaving idle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.accepted) |-> (out_data_o.play_time == '0))
    else $error("rejected packet carries a play time");

  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q != '0)
    else $error("frame rate estimate reached zero");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video playout time scheduler testbench
// Sends audio timestamp events and video packets through the request channel.
// An internal schedule predictor tracks the audio reference, frame count,
// predicted frame time and smoothed rate. Each packet result is compared
// field by field against the predicted one. Directed cases cover rejection,
// repeated stamps, gap boundaries and divisor extremes. Random audio/video
// streams then run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench
  import vpts_pkg::*;
();

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 92;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct  = 16;
  int recv_stall_pct = 78;
  int mismatches     = 0;
  int idle_cycles    = 0;

  out_item_t expected_results[$];

  logic                  sched_enable = 1'b0;
  logic [CFG_DATA_W-1:0] sched_ticks  = RESET_TICKS;
  logic [CFG_DATA_W-1:0] sched_delay  = RESET_DELAY;
  logic [STAMP_W-1:0]    audio_ref    = '0;
  logic [COUNT_BITS-1:0] frame_count  = '0;
  logic [STAMP_W-1:0]    predicted    = '0;
  logic [STAMP_W-1:0]    last_stamp   = '0;
  logic [RATE_W-1:0]     rate_est     = RESET_RATE;

  logic [STAMP_W-1:0]    stream_stamp;
  logic [SEQ_W-1:0]      stream_seq;

  video_playout_time_scheduler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit predict_schedule(input in_item_t req, output out_item_t res);
    logic [63:0]        step;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W-1:0] blended;
    logic [STAMP_W-1:0] divisor;
    res = '0;
    if (req.mode == MODE_AUDIO) begin
      divisor = (sched_ticks == '0) ? 32'd1 : 32'(sched_ticks);
      audio_ref = req.stamp / divisor;
      frame_count = '0;
      return 1'b0;
    end
    res.out_seq = req.packet_seq;
    if (!sched_enable) begin
      res.frame_rate = rate_est;
      return 1'b1;
    end
    if (req.stamp != last_stamp) begin
      divisor = (rate_est == '0) ? 32'd1 : 32'(rate_est);
      step = (64'(MS_PER_SEC) * 64'(frame_count)) / 64'(divisor);
      predicted = audio_ref + step[STAMP_W-1:0];
      if (frame_count != '1) frame_count++;
      gap = req.stamp - last_stamp;
      if (gap < 32'(GAP_MIN) || gap > 32'(GAP_MAX)) begin
        blended = (32'(rate_est) * 32'd3 + 32'(FALLBACK_NEXT) + 32'd2) >> 2;
      end else begin
        blended = (32'(rate_est) + 32'(MS_PER_SEC) / gap + 32'd1) >> 1;
      end
      rate_est = blended[RATE_W-1:0];
    end
    last_stamp = req.stamp;
    res.accepted   = 1'b1;
    res.play_time  = predicted + req.codec_lead - 32'(sched_delay);
    res.frame_rate = rate_est;
    return 1'b1;
  endfunction

  task automatic send_request(input in_item_t req);
    out_item_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_schedule(req, res)) expected_results.push_back(res);
  endtask

  task automatic send_audio(input logic [STAMP_W-1:0] stamp);
    in_item_t req;
    req.mode       = MODE_AUDIO;
    req.stamp      = stamp;
    req.codec_lead = $urandom();
    req.packet_seq = SEQ_W'($urandom());
    send_request(req);
  endtask

  task automatic send_video(input logic [STAMP_W-1:0] stamp, input logic [STAMP_W-1:0] lead,
                            input logic [SEQ_W-1:0] seq);
    in_item_t req;
    req.mode       = MODE_VIDEO;
    req.stamp      = stamp;
    req.codec_lead = lead;
    req.packet_seq = seq;
    send_request(req);
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE: sched_enable = value[0];
      CFG_TICKS:  sched_ticks  = value;
      CFG_DELAY:  sched_delay  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_rejected_when_disabled();
    send_video('0, '0, '0);
    send_audio('1);
    send_video('1, '1, '1);
    wait_until_idle();
  endtask

  task automatic test_frame_timing();
    write_register(CFG_ENABLE, 8'd1);
    send_audio('0);
    send_video(32'd0, '1, 16'd0);
    send_video(32'd33, 32'd0, 16'd1);
    send_video(32'd33, 32'd5, 16'd2);
    send_video(32'd50, 32'd100, 16'd3);
    send_video(32'd55, 32'h8000_0000, 16'd4);
    send_video(32'd1055, 32'd7, 16'd5);
    send_video(32'd2056, 32'd0, 16'd6);
    send_video(32'd2072, 32'd1, 16'h8000);
    send_video(32'd2087, 32'hFFFF_0000, 16'd8);
    send_video(32'd0, 32'd9, 16'hFFFF);
    wait_until_idle();
  endtask

  task automatic test_divisor_extremes();
    write_register(CFG_TICKS, 8'd0);
    send_audio('1);
    send_video(32'd100, 32'd0, 16'd10);
    wait_until_idle();
    write_register(CFG_TICKS, 8'hFF);
    write_register(CFG_DELAY, 8'hFF);
    send_audio('1);
    send_video(32'd200, 32'd0, 16'd11);
    wait_until_idle();
    write_register(CFG_TICKS, 8'd1);
    write_register(CFG_DELAY, 8'd0);
    send_audio(32'd12345);
    send_video(32'd300, 32'd0, 16'd12);
    wait_until_idle();
  endtask

  task automatic run_stream_phase(input int unsigned n_requests);
    int unsigned        sent;
    int unsigned        burst;
    int unsigned        pick;
    logic [STAMP_W-1:0] gap;
    sent = 0;
    while (sent < n_requests) begin
      send_audio($urandom());
      sent++;
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_requests; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) gap = $urandom_range(GAP_MIN, GAP_MAX);
        else if (pick < 72) gap = $urandom_range(30, 42);
        else if (pick < 82) gap = '0;
        else if (pick < 90) gap = $urandom_range(1, GAP_MIN - 1);
        else gap = $urandom();
        stream_stamp += gap;
        if ($urandom_range(9) == 0) stream_seq = SEQ_W'($urandom());
        else stream_seq++;
        send_video(stream_stamp, $urandom(), stream_seq);
        sent++;
      end
    end
    wait_until_idle();
  endtask

  task automatic test_random_streams();
    logic [CFG_DATA_W-1:0] ticks;
    logic [CFG_DATA_W-1:0] delay;
    stream_stamp = $urandom();
    stream_seq   = SEQ_W'($urandom());
    for (int p = 0; p < 6; p++) begin
      send_idle_pct  = (p < 2) ? 16 : (p < 4) ? 78 : 0;
      recv_stall_pct = (p < 2) ? 78 : (p < 4) ? 16 : 0;
      case (p)
        0:       begin ticks = 8'd16;  delay = 8'd30;  end
        1:       begin ticks = 8'd1;   delay = 8'd255; end
        2:       begin ticks = 8'd192; delay = 8'd0;   end
        3:       begin ticks = 8'd0;   delay = CFG_DATA_W'($urandom()); end
        4:       begin ticks = 8'd255; delay = 8'd128; end
        default: begin
          ticks = CFG_DATA_W'($urandom_range(1, 192));
          delay = CFG_DATA_W'($urandom());
        end
      endcase
      write_register(CFG_ENABLE, (p == 3) ? 8'd0 : 8'd1);
      write_register(CFG_TICKS, ticks);
      write_register(CFG_DELAY, delay);
      run_stream_phase(PHASE_REQUESTS);
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_seq %0h", out_data.out_seq);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          mismatches++;
        end
        if (out_data.play_time !== want.play_time) begin
          $error("play_time: expected %0h, got %0h", want.play_time, out_data.play_time);
          mismatches++;
        end
        if (out_data.frame_rate !== want.frame_rate) begin
          $error("frame_rate: expected %0d, got %0d", want.frame_rate, out_data.frame_rate);
          mismatches++;
        end
        if (out_data.out_seq !== want.out_seq) begin
          $error("out_seq: expected %0h, got %0h", want.out_seq, out_data.out_seq);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("video_playout_time_scheduler test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_rejected_when_disabled();
    test_frame_timing();
    test_divisor_extremes();
    test_random_streams();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("video_playout_time_scheduler test passed");
    end else begin
      $display("video_playout_time_scheduler test failed");
    end
    $finish;
  end

endmodule
